// ===== rtl/ajd_pkg.sv =====
// Shared types, constants and helpers for the jostle detector.
`timescale 1ns / 1ps

package ajd_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_PREP,
    ST_ROOT,
    ST_FAST_LOAD,
    ST_DIV_FAST,
    ST_SLOW_LOAD,
    ST_DIV_SLOW,
    ST_FINISH
  } ajd_state_t;

  // Request kinds carried on in_tuser.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Register index as decoded from cfg_paddr[2].
  localparam logic REG_THRESH = 1'b0;

  localparam int          AVG_W        = 16;
  localparam int          DIV_W        = 20;  // holds 7*a + 3*b for 16-bit a and b
  localparam int          CNT_W        = 5;
  localparam int          ROOT_IN_W    = 32;
  localparam int          OUT_W        = 56;
  localparam logic [15:0] THRESH_RESET = 16'd655;
  localparam logic [15:0] MAG_MAX      = 16'hFFFF;
  localparam logic [3:0]  DIVISOR      = 4'd10;
  localparam logic [CNT_W-1:0] ROOT_LAST = 5'd15;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd19;

  // Weighted sum 7*a + 3*b that feeds the divide by ten.
  function automatic logic [DIV_W-1:0] mix73(input logic [AVG_W-1:0] a,
                                             input logic [AVG_W-1:0] b);
    logic [DIV_W-1:0] ea;
    logic [DIV_W-1:0] eb;
    ea = DIV_W'(a);
    eb = DIV_W'(b);
    return (ea << 3) - ea + (eb << 1) + eb;
  endfunction

endpackage

// ===== rtl/accel_jostle_detector_core.sv =====
// Jostle detector: serial magnitude, dual moving average and threshold latch.
`timescale 1ns / 1ps

//  channel  | direction | handshake                 | payload
//  in_      | slave     | in_tvalid / in_tready     | tdata {time_now,z,y,x}, tuser req_type
//  out_     | master    | out_tvalid / out_tready   | tdata {magnitude,time,now,flag}
//  cfg_     | APB slave | psel, penable, pready = 1 | jostle_threshold at address 0
//
// A sample request works out one bit of each square per cycle, one root bit per cycle
// and one quotient bit per cycle for each of the two divides by ten before its result
// is loaded. A clear request goes straight to the finish state, where its result is
// loaded. The block returns to idle as the result is loaded, so the next request is
// accepted in the cycle after at the earliest.
// Reset is synchronous and active low; it clears the averages, flag and time.
// The output register holds a result until taken, and a new request is accepted
// while it waits; a request that finishes before then waits in its last state.
module accel_jostle_detector_core #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // accel_x, accel_y, accel_z, time_now, then zero fill
  input  logic [((3*SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] in_tdata,
  // req_type
  input  logic [0:0]                               in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // jostle_flag, jostle_now, last_jostle_time, magnitude, then zero fill
  output logic [ajd_pkg::OUT_W-1:0]                out_tdata,
  input  logic                                     cfg_psel,
  input  logic                                     cfg_penable,
  input  logic                                     cfg_pwrite,
  input  logic [2:0]                               cfg_paddr,
  input  logic [31:0]                              cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int SQW = 2 * SAMPLE_BITS;
  localparam int NW  = 2 * SAMPLE_BITS + 2 * FRAC_BITS;
  localparam int XL  = 0;
  localparam int YL  = SAMPLE_BITS;
  localparam int ZL  = 2 * SAMPLE_BITS;
  localparam int TL  = 3 * SAMPLE_BITS;
  localparam logic [ajd_pkg::CNT_W-1:0] SQ_LAST = ajd_pkg::CNT_W'(SAMPLE_BITS - 1);
  localparam logic [1:0] AXIS_LAST = 2'd2;

  ajd_pkg::ajd_state_t state_r, state_nxt;

  logic [15:0]                 thresh_r;
  logic [ajd_pkg::CNT_W-1:0]   cnt_r;
  logic [1:0]                  axis_r;
  logic                        kind_r;
  logic [SQW-1:0]              acc_r;
  logic [SQW-1:0]              mcand_r;
  logic [SAMPLE_BITS-1:0]      mplier_r;
  logic [SAMPLE_BITS-1:0]      ay_r;
  logic [SAMPLE_BITS-1:0]      az_r;
  logic [TIME_BITS-1:0]        time_r;
  logic [ajd_pkg::ROOT_IN_W-1:0] sq_n_r;
  logic                        sat_r;
  logic [16:0]                 rem_r;
  logic [15:0]                 root_r;
  logic [15:0]                 mag_r;
  logic [ajd_pkg::DIV_W-1:0]   div_r;
  logic [3:0]                  drem_r;
  logic [15:0]                 fast_new_r;
  logic [15:0]                 fast_r;
  logic [15:0]                 slow_r;
  logic                        seeded_r;
  logic                        latched_r;
  logic [TIME_BITS-1:0]        jtime_r;
  logic                        out_valid_r;
  logic                        out_flag_r;
  logic                        out_now_r;
  logic [31:0]                 out_time_r;
  logic [15:0]                 out_mag_r;

  logic                        in_fire;
  logic                        load_out;
  logic                        cfg_write;
  logic [SAMPLE_BITS-1:0]      ax_raw, ay_raw, az_raw;
  logic [SAMPLE_BITS-1:0]      ax_abs, ay_abs, az_abs;
  logic [SQW-1:0]              acc_nxt;
  logic [NW-1:0]               n_full;
  logic [18:0]                 rem_t;
  logic [18:0]                 trial;
  logic                        root_bit;
  logic [15:0]                 mag_now;
  logic [4:0]                  div_t;
  logic                        q_bit;
  logic [15:0]                 slow_new;
  logic [15:0]                 diff;
  logic                        hit;

  // Operand preparation.
  always_comb begin
    ax_raw = in_tdata[XL +: SAMPLE_BITS];
    ay_raw = in_tdata[YL +: SAMPLE_BITS];
    az_raw = in_tdata[ZL +: SAMPLE_BITS];
    // The most negative sample maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
    ax_abs = ax_raw[SAMPLE_BITS-1] ? (~ax_raw + 1'b1) : ax_raw;
    ay_abs = ay_raw[SAMPLE_BITS-1] ? (~ay_raw + 1'b1) : ay_raw;
    az_abs = az_raw[SAMPLE_BITS-1] ? (~az_raw + 1'b1) : az_raw;
  end

  // Serial datapath steps.
  always_comb begin
    acc_nxt  = acc_r + (mplier_r[0] ? mcand_r : '0);
    n_full   = NW'(acc_r) << (2 * FRAC_BITS);
    rem_t    = {rem_r, sq_n_r[ajd_pkg::ROOT_IN_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    root_bit = (rem_t >= trial);
    mag_now  = sat_r ? ajd_pkg::MAG_MAX : root_r;
    div_t    = {drem_r, div_r[ajd_pkg::DIV_W-1]};
    q_bit    = (div_t >= {1'b0, ajd_pkg::DIVISOR});
    slow_new = div_r[15:0];
    diff     = (slow_new > fast_new_r) ? (slow_new - fast_new_r) : (fast_new_r - slow_new);
    hit      = (diff > thresh_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ajd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser[0] == ajd_pkg::REQ_CLEAR) ? ajd_pkg::ST_FINISH
                                                          : ajd_pkg::ST_SQUARE;
        end
      end
      ajd_pkg::ST_SQUARE: begin
        if (cnt_r == SQ_LAST && axis_r == AXIS_LAST) begin
          state_nxt = ajd_pkg::ST_PREP;
        end
      end
      ajd_pkg::ST_PREP:      state_nxt = ajd_pkg::ST_ROOT;
      ajd_pkg::ST_ROOT: begin
        if (cnt_r == ajd_pkg::ROOT_LAST) begin
          state_nxt = ajd_pkg::ST_FAST_LOAD;
        end
      end
      ajd_pkg::ST_FAST_LOAD: state_nxt = ajd_pkg::ST_DIV_FAST;
      ajd_pkg::ST_DIV_FAST: begin
        if (cnt_r == ajd_pkg::DIV_LAST) begin
          state_nxt = ajd_pkg::ST_SLOW_LOAD;
        end
      end
      ajd_pkg::ST_SLOW_LOAD: state_nxt = ajd_pkg::ST_DIV_SLOW;
      ajd_pkg::ST_DIV_SLOW: begin
        if (cnt_r == ajd_pkg::DIV_LAST) begin
          state_nxt = ajd_pkg::ST_FINISH;
        end
      end
      ajd_pkg::ST_FINISH: begin
        if (load_out) begin
          state_nxt = ajd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ajd_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready = (state_r == ajd_pkg::ST_IDLE);
    load_out  = (state_r == ajd_pkg::ST_FINISH) && (!out_valid_r || out_tready);
  end

  assign in_fire    = in_tvalid && in_tready;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ajd_pkg::REG_THRESH) ? {16'd0, thresh_r} : 32'd0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_mag_r, out_time_r, out_now_r, out_flag_r};

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ajd_pkg::ST_IDLE;
      thresh_r    <= ajd_pkg::THRESH_RESET;
      fast_r      <= '0;
      slow_r      <= '0;
      seeded_r    <= 1'b0;
      latched_r   <= 1'b0;
      jtime_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write && cfg_paddr[2] == ajd_pkg::REG_THRESH) begin
        thresh_r <= cfg_pwdata[15:0];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        if (kind_r == ajd_pkg::REQ_CLEAR) begin
          latched_r <= 1'b0;
        end else begin
          fast_r   <= fast_new_r;
          slow_r   <= slow_new;
          seeded_r <= 1'b1;
          if (hit) begin
            latched_r <= 1'b1;
            jtime_r   <= time_r;
          end
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Serial datapath and output payload.
  always_ff @(posedge clk) begin
    unique case (state_r) inside
      ajd_pkg::ST_IDLE: begin
        cnt_r    <= '0;
        axis_r   <= '0;
        acc_r    <= '0;
        kind_r   <= in_tuser[0];
        mcand_r  <= SQW'(ax_abs);
        mplier_r <= ax_abs;
        ay_r     <= ay_abs;
        az_r     <= az_abs;
        time_r   <= in_tdata[TL +: TIME_BITS];
      end
      ajd_pkg::ST_SQUARE: begin
        acc_r <= acc_nxt;
        if (cnt_r == SQ_LAST) begin
          cnt_r    <= '0;
          axis_r   <= axis_r + 2'd1;
          mcand_r  <= SQW'(ay_r);
          mplier_r <= ay_r;
          ay_r     <= az_r;
        end else begin
          cnt_r    <= cnt_r + ajd_pkg::CNT_W'(1);
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
      end
      ajd_pkg::ST_PREP: begin
        // Roots at or beyond 2^16 saturate, so only the low 32 bits are rooted.
        sat_r  <= (n_full >> ajd_pkg::ROOT_IN_W) != '0;
        sq_n_r <= ajd_pkg::ROOT_IN_W'(n_full);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      ajd_pkg::ST_ROOT: begin
        cnt_r  <= cnt_r + ajd_pkg::CNT_W'(1);
        sq_n_r <= sq_n_r << 2;
        root_r <= {root_r[14:0], root_bit};
        rem_r  <= root_bit ? 17'(rem_t - trial) : rem_t[16:0];
      end
      ajd_pkg::ST_FAST_LOAD: begin
        mag_r  <= mag_now;
        div_r  <= ajd_pkg::mix73(seeded_r ? fast_r : mag_now, mag_now);
        drem_r <= '0;
        cnt_r  <= '0;
      end
      ajd_pkg::ST_DIV_FAST, ajd_pkg::ST_DIV_SLOW: begin
        cnt_r  <= cnt_r + ajd_pkg::CNT_W'(1);
        div_r  <= {div_r[ajd_pkg::DIV_W-2:0], q_bit};
        drem_r <= q_bit ? 4'(div_t - {1'b0, ajd_pkg::DIVISOR}) : div_t[3:0];
      end
      ajd_pkg::ST_SLOW_LOAD: begin
        fast_new_r <= div_r[15:0];
        div_r      <= ajd_pkg::mix73(seeded_r ? slow_r : mag_r, div_r[15:0]);
        drem_r     <= '0;
        cnt_r      <= '0;
      end
      ajd_pkg::ST_FINISH: begin
        if (load_out) begin
          if (kind_r == ajd_pkg::REQ_CLEAR) begin
            out_flag_r <= 1'b0;
            out_now_r  <= 1'b0;
            out_time_r <= 32'(jtime_r);
            out_mag_r  <= '0;
          end else begin
            out_flag_r <= hit | latched_r;
            out_now_r  <= hit;
            out_time_r <= hit ? 32'(time_r) : 32'(jtime_r);
            out_mag_r  <= mag_r;
          end
        end
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

  // Once seeded, the averages stay seeded until reset.
  a_seeded_holds: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped without reset");

  // The divider remainder stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ajd_pkg::ST_DIV_FAST || state_r == ajd_pkg::ST_DIV_SLOW)
      |-> (drem_r < ajd_pkg::DIVISOR))
    else $error("divider remainder out of range");

  // The root remainder never exceeds twice the partial root.
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ajd_pkg::ST_ROOT) |-> (rem_r <= {root_r, 1'b0}))
    else $error("root remainder out of range");

  // A crossing reported on a result always shows the latched flag.
  a_now_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_now_r) |-> out_flag_r)
    else $error("jostle_now without jostle_flag");

endmodule
